@@ design/daac_pkg.sv @@
package daac_pkg;

  localparam logic [1:0] MODE_DISARMED  = 2'd0;
  localparam logic [1:0] MODE_ARMED     = 2'd1;
  localparam logic [1:0] MODE_TRIGGERED = 2'd2;

  localparam int unsigned US_PER_MS = 1000;
  localparam int unsigned FRAC_MAX  = US_PER_MS - 1;
  localparam int unsigned HALF_MIN  = 2;

  // Configuration register indexes.
  localparam logic [1:0] REG_TICK_WHOLE = 2'd0;
  localparam logic [1:0] REG_TICK_FRAC  = 2'd1;
  localparam logic [1:0] REG_LOCKOUT    = 2'd2;
  localparam logic [1:0] REG_BLINK_HALF = 2'd3;

  localparam logic [7:0]  TICK_WHOLE_RESET = 8'd1;
  localparam logic [9:0]  TICK_FRAC_RESET  = 10'd24;
  localparam logic [15:0] LOCKOUT_RESET    = 16'd50;
  localparam logic [15:0] BLINK_HALF_RESET = 16'd150;

endpackage

@@ design/debounced_alarm_arm_controller.sv @@
// Debounced alarm arm controller.
// Input channel (in_valid/in_ready) carries one item per sample: a timer
// tick flag and falling-edge flags for the sensor and the arm button.
// Output channel (out_valid/out_ready) returns one item for every input
// item: the alarm state, the LED drive and the millisecond clock.
// Configuration is written through cfg_we/cfg_addr/cfg_data, one register
// per cycle; the user must write it only while no item is in flight, as
// the block does not enforce this. out_valid rises in the cycle after
// acceptance, and a new item can be taken in every cycle while the output
// register is empty or being taken and no configuration pass is running.
// Each configuration write starts a pass, one bit a cycle, that refits the
// blink step and the blink position to the new settings; in_ready is low
// while the pass runs. If out_ready is low, the result stays in the output
// register and in_ready drops until it is taken.
// Synchronous reset restores the configuration defaults, clears the clock,
// the edge timestamps and the blink state, and leaves the alarm disarmed
// with no result pending.
module debounced_alarm_arm_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        tick,
  input  logic        sensor_edge,
  input  logic        arm_edge,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  alarm_state,
  output logic        led_on,
  output logic [31:0] now_ms
);
  import daac_pkg::*;

  logic [7:0]  reg_whole;
  logic [9:0]  reg_frac;
  logic [15:0] reg_lockout;
  logic [15:0] reg_half;

  logic [31:0] clock_ms;
  logic [9:0]  clock_frac_us;
  logic [31:0] last_sensor_ms;
  logic [31:0] last_button_ms;
  logic [1:0]  mode;
  logic [15:0] blink_count_ms;
  logic        blink_off_phase;
  logic [16:0] blink_pos_ms;
  logic [7:0]  tick_step;

  logic        busy;
  logic [3:0]  norm_cnt;
  logic [15:0] norm_rem_c;
  logic [7:0]  norm_rem_w;

  logic        accept;
  logic [9:0]  frac_inc;
  logic [10:0] frac_sum;
  logic        frac_carry;
  logic [9:0]  frac_next;
  logic [8:0]  delta;
  logic [31:0] clock_next;
  logic        sensor_seen;
  logic        s_event;
  logic        a_event;
  logic        enter_trig;
  logic [1:0]  mode_mid;
  logic [1:0]  mode_next;
  logic        advance;
  logic [15:0] half_eff;
  logic [16:0] half_dbl;
  logic [16:0] step_plus;
  logic [16:0] blink_step;
  logic [17:0] pos_sum;
  logic [16:0] pos_next;
  logic        phase_next;
  logic [15:0] count_next;
  logic        led_next;
  logic [15:0] norm_whole;
  logic [16:0] nc_shift;
  logic        nc_ge;
  logic [15:0] nc_new;
  logic [8:0]  nw_shift;
  logic        nw_ge;
  logic [7:0]  nw_new;
  logic [16:0] norm_pos;

  assign in_ready = !busy && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    frac_inc   = (reg_frac > 10'(FRAC_MAX)) ? 10'(FRAC_MAX) : reg_frac;
    frac_sum   = {1'b0, clock_frac_us} + {1'b0, frac_inc};
    frac_carry = frac_sum >= 11'(US_PER_MS);
    frac_next  = frac_carry ? 10'(frac_sum - 11'(US_PER_MS)) : frac_sum[9:0];
    delta      = {1'b0, reg_whole} + {8'd0, frac_carry};
    clock_next = tick ? clock_ms + {23'd0, delta} : clock_ms;

    // Sensor edges are dropped altogether while disarmed, timestamp included.
    sensor_seen = sensor_edge && (mode != MODE_DISARMED);
    s_event = sensor_seen && ((clock_next - last_sensor_ms) >= {16'd0, reg_lockout});
    a_event = arm_edge && ((clock_next - last_button_ms) >= {16'd0, reg_lockout});

    enter_trig = s_event && (mode == MODE_ARMED);
    mode_mid   = enter_trig ? MODE_TRIGGERED : mode;
    if (a_event) begin
      mode_next = (mode_mid == MODE_DISARMED) ? MODE_ARMED : MODE_DISARMED;
    end else begin
      mode_next = mode_mid;
    end

    // The blink state only matters if the alarm is still triggered afterwards.
    advance = tick && (mode == MODE_TRIGGERED) && (mode_next == MODE_TRIGGERED);

    half_eff = (reg_half < 16'(HALF_MIN)) ? 16'(HALF_MIN) : reg_half;
    half_dbl = {half_eff, 1'b0};

    // The blink position runs over a full period of two half periods, so a
    // tick moves it by the clock step already reduced modulo that period.
    step_plus = {9'd0, tick_step} + 17'd1;
    if (!frac_carry) begin
      blink_step = {9'd0, tick_step};
    end else if (step_plus == half_dbl) begin
      blink_step = '0;
    end else begin
      blink_step = step_plus;
    end
    pos_sum    = {1'b0, blink_pos_ms} + {1'b0, blink_step};
    pos_next   = (pos_sum >= {1'b0, half_dbl}) ? 17'(pos_sum - {1'b0, half_dbl})
                                               : pos_sum[16:0];
    phase_next = pos_next >= {1'b0, half_eff};
    count_next = phase_next ? 16'(pos_next - {1'b0, half_eff}) : pos_next[15:0];

    case (mode_next)
      MODE_DISARMED: led_next = 1'b0;
      MODE_ARMED:    led_next = 1'b1;
      MODE_TRIGGERED: begin
        if (enter_trig) begin
          led_next = 1'b1;
        end else if (advance) begin
          led_next = !phase_next;
        end else begin
          led_next = !blink_off_phase;
        end
      end
      default:       led_next = 1'b0;
    endcase

    // One restoring step for the count modulo the half period and one for
    // the whole step modulo the full period.
    norm_whole = {8'd0, reg_whole};
    nc_shift   = {norm_rem_c, blink_count_ms[norm_cnt]};
    nc_ge      = nc_shift >= {1'b0, half_eff};
    nc_new     = nc_ge ? 16'(nc_shift - {1'b0, half_eff}) : nc_shift[15:0];
    nw_shift   = {norm_rem_w, norm_whole[norm_cnt]};
    nw_ge      = {8'd0, nw_shift} >= half_dbl;
    nw_new     = nw_ge ? 8'({8'd0, nw_shift} - half_dbl) : nw_shift[7:0];
    // The parity of the last quotient bit tells which half the count lands in.
    norm_pos   = (blink_off_phase ^ nc_ge) ? {1'b0, half_eff} + {1'b0, nc_new}
                                           : {1'b0, nc_new};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_whole   <= TICK_WHOLE_RESET;
      reg_frac    <= TICK_FRAC_RESET;
      reg_lockout <= LOCKOUT_RESET;
      reg_half    <= BLINK_HALF_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_TICK_WHOLE: reg_whole   <= cfg_data[7:0];
        REG_TICK_FRAC:  reg_frac    <= cfg_data[9:0];
        REG_LOCKOUT:    reg_lockout <= cfg_data;
        REG_BLINK_HALF: reg_half    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_ms        <= '0;
      clock_frac_us   <= '0;
      last_sensor_ms  <= '0;
      last_button_ms  <= '0;
      mode            <= MODE_DISARMED;
      blink_count_ms  <= '0;
      blink_off_phase <= 1'b0;
      blink_pos_ms    <= '0;
      // The default whole step is already shorter than a full blink period.
      tick_step       <= TICK_WHOLE_RESET;
      busy            <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        busy       <= 1'b1;
        norm_cnt   <= 4'd15;
        norm_rem_c <= '0;
        norm_rem_w <= '0;
      end else if (busy) begin
        norm_rem_c <= nc_new;
        norm_rem_w <= nw_new;
        norm_cnt   <= norm_cnt - 4'd1;
        if (norm_cnt == 4'd0) begin
          blink_pos_ms <= norm_pos;
          tick_step    <= nw_new;
          busy         <= 1'b0;
        end
      end

      if (accept) begin
        if (tick) begin
          clock_frac_us <= frac_next;
          clock_ms      <= clock_next;
        end
        if (sensor_seen) begin
          last_sensor_ms <= clock_next;
        end
        if (arm_edge) begin
          last_button_ms <= clock_next;
        end
        mode        <= mode_next;
        alarm_state <= mode_next;
        now_ms      <= clock_next;
        led_on      <= led_next;

        if (enter_trig) begin
          blink_count_ms  <= '0;
          blink_off_phase <= 1'b0;
          blink_pos_ms    <= '0;
        end else if (advance) begin
          blink_count_ms  <= count_next;
          blink_off_phase <= phase_next;
          blink_pos_ms    <= pos_next;
        end
      end
    end
  end

endmodule

@@ sim/daac_checker.sv @@
module daac_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        tick,
  input  logic        sensor_edge,
  input  logic        arm_edge,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  alarm_state,
  input  logic        led_on,
  input  logic [31:0] now_ms,
  output int          outstanding,
  output int          fail_count
);
  import daac_pkg::*;

  typedef struct packed {
    logic [1:0]  state;
    logic        led;
    logic [31:0] ms;
  } alarm_status_t;

  alarm_status_t status_q[$];
  int reported;

  logic [7:0]  cfg_whole;
  logic [9:0]  cfg_frac;
  logic [15:0] cfg_lockout;
  logic [15:0] cfg_half;

  logic [31:0] ms_clock;
  logic [9:0]  us_frac;
  logic [31:0] sensor_stamp;
  logic [31:0] button_stamp;
  logic [1:0]  mode;
  int unsigned blink_ms;
  logic        blink_dark;

  function automatic alarm_status_t step_alarm(input logic t, input logic s, input logic a);
    int unsigned inc, f, delta, half, total;
    logic s_event, a_event;
    alarm_status_t r;
    s_event = 1'b0;
    a_event = 1'b0;
    if (t) begin
      inc = (cfg_frac > FRAC_MAX) ? FRAC_MAX : cfg_frac;
      f = us_frac + inc;
      delta = cfg_whole;
      if (f >= US_PER_MS) begin
        f = f - US_PER_MS;
        delta = delta + 1;
      end
      us_frac = 10'(f);
      ms_clock = ms_clock + delta;
      // While triggered the blink counter advances by exactly what the clock did.
      if (mode == MODE_TRIGGERED) begin
        half = (cfg_half < HALF_MIN) ? HALF_MIN : cfg_half;
        total = blink_ms + delta;
        blink_ms = total % half;
        if (((total / half) & 1) != 0) blink_dark = ~blink_dark;
      end
    end
    // A sensor edge seen while disarmed leaves no trace, not even its timestamp.
    if (s && mode != MODE_DISARMED) begin
      if (ms_clock - sensor_stamp >= cfg_lockout) s_event = 1'b1;
      sensor_stamp = ms_clock;
    end
    if (a) begin
      if (ms_clock - button_stamp >= cfg_lockout) a_event = 1'b1;
      button_stamp = ms_clock;
    end
    if (s_event && mode == MODE_ARMED) begin
      mode = MODE_TRIGGERED;
      blink_ms = 0;
      blink_dark = 1'b0;
    end
    if (a_event) mode = (mode == MODE_DISARMED) ? MODE_ARMED : MODE_DISARMED;
    r.state = mode;
    case (mode)
      MODE_DISARMED: r.led = 1'b0;
      MODE_ARMED:    r.led = 1'b1;
      default:       r.led = ~blink_dark;
    endcase
    r.ms = ms_clock;
    return r;
  endfunction

  task automatic log_mismatch(input string what, input alarm_status_t want,
                              input alarm_status_t got);
    fail_count = fail_count + 1;
    if (reported < 10) begin
      reported = reported + 1;
      $display("%0t %s: expected state %0d led %0d ms %0d, got state %0d led %0d ms %0d",
               $realtime, what, want.state, want.led, want.ms, got.state, got.led, got.ms);
    end
  endtask

  always @(posedge clk) begin
    alarm_status_t want, got;
    if (rst) begin
      status_q.delete();
      cfg_whole = TICK_WHOLE_RESET;
      cfg_frac = TICK_FRAC_RESET;
      cfg_lockout = LOCKOUT_RESET;
      cfg_half = BLINK_HALF_RESET;
      ms_clock = '0;
      us_frac = '0;
      sensor_stamp = '0;
      button_stamp = '0;
      mode = MODE_DISARMED;
      blink_ms = 0;
      blink_dark = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_TICK_WHOLE: cfg_whole = cfg_data[7:0];
          REG_TICK_FRAC:  cfg_frac = cfg_data[9:0];
          REG_LOCKOUT:    cfg_lockout = cfg_data;
          REG_BLINK_HALF: cfg_half = cfg_data;
          default: ;
        endcase
      end
      // Results are checked before this edge's item is predicted, as the
      // block answers from a register.
      if (out_valid && out_ready) begin
        got = '{state: alarm_state, led: led_on, ms: now_ms};
        if (status_q.size() == 0) begin
          log_mismatch("unexpected result", got, got);
        end else begin
          want = status_q.pop_front();
          if (got.state !== want.state || got.led !== want.led || got.ms !== want.ms)
            log_mismatch("result mismatch", want, got);
        end
      end
      if (in_valid && in_ready) status_q.push_back(step_alarm(tick, sensor_edge, arm_edge));
    end
    outstanding = status_q.size();
  end

endmodule

@@ sim/tb_debounced_alarm_arm_controller.sv @@
module tb_debounced_alarm_arm_controller;
  import daac_pkg::*;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        tick;
  logic        sensor_edge;
  logic        arm_edge;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  alarm_state;
  logic        led_on;
  logic [31:0] now_ms;

  int outstanding;
  int fail_count;
  bit calm;
  int rx_hold = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  debounced_alarm_arm_controller dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .tick(tick), .sensor_edge(sensor_edge), .arm_edge(arm_edge),
    .out_valid(out_valid), .out_ready(out_ready),
    .alarm_state(alarm_state), .led_on(led_on), .now_ms(now_ms)
  );

  daac_checker u_check (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .tick(tick), .sensor_edge(sensor_edge), .arm_edge(arm_edge),
    .out_valid(out_valid), .out_ready(out_ready),
    .alarm_state(alarm_state), .led_on(led_on), .now_ms(now_ms),
    .outstanding(outstanding), .fail_count(fail_count)
  );

  function automatic int pick_gap();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
  endfunction

  // Result stalls: none during calm stretches, otherwise mostly short ones.
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!calm && $urandom_range(0, 5) == 0) rx_hold <= pick_gap();
    end
  end

  // Bits are {tick, sensor_edge, arm_edge}.
  task automatic send_item(input logic [2:0] bits, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    {tick, sensor_edge, arm_edge} <= bits;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_config(input logic [7:0] w, input logic [9:0] f,
                            input logic [15:0] l, input logic [15:0] h);
    settle();
    write_reg(REG_TICK_WHOLE, 16'(w));
    write_reg(REG_TICK_FRAC, 16'(f));
    write_reg(REG_LOCKOUT, l);
    write_reg(REG_BLINK_HALF, h);
  endtask

  initial begin
    int sent;
    int phase_len;
    logic [7:0]  w;
    logic [9:0]  f;
    logic [15:0] l;
    logic [15:0] h;
    logic [2:0]  bits;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    tick = 1'b0;
    sensor_edge = 1'b0;
    arm_edge = 1'b0;
    calm = 1'b1;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Default settings: edges close to time zero fall inside the lockout.
    send_item(3'b000, 0);
    send_item(3'b001, 0);
    send_item(3'b010, 0);
    send_item(3'b111, 0);

    // Largest steps, no lockout, blink half period below its floor.
    set_config(8'd255, 10'd999, 16'd0, 16'd0);
    send_item(3'b100, 0);
    send_item(3'b100, 0);
    send_item(3'b001, 0);
    send_item(3'b110, 0);
    send_item(3'b100, 0);
    send_item(3'b100, 0);
    send_item(3'b011, 0);
    send_item(3'b001, 0);
    send_item(3'b011, 0);
    send_item(3'b010, 0);

    // No whole step, fraction above its range, longest lockout.
    set_config(8'd0, 10'd1023, 16'd65535, 16'd1);
    send_item(3'b100, 0);
    send_item(3'b100, 0);
    send_item(3'b001, 0);
    send_item(3'b010, 0);
    send_item(3'b111, 0);

    set_config(8'd3, 10'd500, 16'd5, 16'd7);
    send_item(3'b001, 0);
    send_item(3'b100, 0);
    send_item(3'b100, 0);
    send_item(3'b010, 0);
    send_item(3'b100, 0);
    send_item(3'b100, 0);

    sent = 0;
    while (sent < 1450) begin
      case ($urandom_range(0, 3))
        0: w = 8'd0;
        1: w = 8'd255;
        default: w = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 3))
        0: f = 10'd0;
        1: f = 10'd999;
        2: f = 10'($urandom_range(1000, 1023));
        default: f = 10'($urandom_range(0, 1023));
      endcase
      case ($urandom_range(0, 7))
        0: l = 16'd0;
        1: l = 16'd65535;
        2: l = 16'($urandom_range(0, 65535));
        default: l = 16'($urandom_range(1, 40));
      endcase
      case ($urandom_range(0, 7))
        0: h = 16'($urandom_range(0, 1));
        1: h = 16'd2;
        2: h = 16'd65535;
        3: h = 16'($urandom_range(0, 65535));
        default: h = 16'($urandom_range(3, 400));
      endcase
      set_config(w, f, l, h);
      calm = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(100, 140);
      repeat (phase_len) begin
        bits[2] = ($urandom_range(0, 3) != 0);
        bits[1] = ($urandom_range(0, 3) == 0);
        bits[0] = ($urandom_range(0, 7) == 0);
        send_item(bits, (!calm && $urandom_range(0, 3) == 0) ? pick_gap() : 0);
        sent = sent + 1;
      end
    end

    settle();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #7200000;
    $display("Some tests failed");
    $finish;
  end

endmodule
